FILE: design/gru_pkg.sv
//------------------------------------------------------------------------------
// gru_pkg
// Shared constants and types of the plane rotation unit.
//------------------------------------------------------------------------------
package gru_pkg;

  localparam int DATA_WIDTH_DEF     = 32;
  localparam int COEF_FRAC_BITS_DEF = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQUARE,
    ST_SQRT,
    ST_RECIP,
    ST_OTHER,
    ST_ROT1,
    ST_ROT2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctrl_t;

endpackage

FILE: design/gru_serial_mul.sv
//------------------------------------------------------------------------------
// gru_serial_mul
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
//------------------------------------------------------------------------------
module gru_serial_mul #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  gru_pkg::mul_ctrl_t ctrl_in,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic [2*W-1:0] product,
  output logic           done
);

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] acc;
  logic [2*W-1:0] addend;
  logic [W-1:0]   bits;
  logic [CW-1:0]  count;
  logic           running;

  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl_in.start && !running) begin
        running <= 1'b1;
        acc     <= '0;
        addend  <= {{W{1'b0}}, mcand};
        bits    <= mplier;
        count   <= CW'(W);
      end else if (running) begin
        if (bits[0]) begin
          acc <= acc + addend;
        end
        addend <= addend << 1;
        bits   <= bits >> 1;
        count  <= count - 1'b1;
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/givens_rotation_unit.sv
//------------------------------------------------------------------------------
// givens_rotation_unit
// Computes and applies plane rotations on Q16.16 element pairs.
//------------------------------------------------------------------------------
// One input channel (s_axis) and one output channel (m_axis) carry one beat
// each per item. tuser of the input beat is the mode: 0 computes the cosine
// and sine that zero the second element and stores them, 1 rotates the pair
// with the stored coefficients, saturating to the element range.
// The block works on one item at a time. A compute item runs a bit-serial
// divider (DW+F+1 steps), a serial multiplier for tau squared, a bit-pair
// square root (F+2 steps), a reciprocal division (2F+1 steps) and a second
// multiply. A compute item with a zero second element goes straight to the
// last step, where its output beat is loaded. A rotate item uses the shared
// serial multiplier four times. The output beat waits in its own register
// until the receiver takes it; the next item can be taken in the cycle after
// a result is loaded and is worked on while that result waits, and a
// finished item holds in its last step until the register is free.
// Reset loads the identity rotation (cosine 1.0, sine 0.0) and empties the
// output register.
//------------------------------------------------------------------------------
module givens_rotation_unit #(
  parameter int DATA_WIDTH     = gru_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = gru_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // first_value, second_value
  input  logic [2*DATA_WIDTH-1:0]   s_axis_tdata,
  // mode
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // rotated_first, rotated_second, cosine_out, sine_out
  output logic [2*DATA_WIDTH+2*(COEF_FRAC_BITS+2)-1:0] m_axis_tdata,
  // saturated
  output logic                      m_axis_tuser
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int DW = DATA_WIDTH;
  localparam int MW = (2 * F + 2 > DW + 1) ? 2 * F + 2 : DW + 1;
  localparam int PW = 2 * MW;
  localparam int NW = (2 * F + 2 > DW + F - 1) ? 2 * F + 2 : DW + F - 1;
  localparam int KW = $clog2(NW + 2);

  gru_pkg::state_t state, state_next;

  logic signed [CW-1:0] cosine, sine;
  logic signed [DW-1:0] x, y;
  logic                 is_rot;
  logic [MW-1:0]        ma, mb;
  logic                 b_larger, neg;
  logic [MW-1:0]        tau, rval, root;
  logic [NW+1:0]        num, rem;
  logic [MW-1:0]        den, quo;
  logic [KW-1:0]        steps;
  logic [2*F+3:0]       sq_n, sq_res, sq_bit;
  logic [1:0]           term;
  logic signed [PW+1:0] p_acc;
  logic                 clip;
  logic signed [DW-1:0] res1, res2;
  logic                 out_valid;
  logic                 out_clip;
  logic                 out_load;
  logic [DW-1:0]        out_first, out_second;
  logic [CW-1:0]        out_cos, out_sin;

  gru_pkg::mul_ctrl_t   mctrl;
  logic [MW-1:0]        m_a, m_b;
  logic [PW-1:0]        m_p;
  logic                 m_done;

  gru_serial_mul #(.W(MW)) u_mul (
    .clk(clk), .rst(rst), .ctrl_in(mctrl), .mcand(m_a), .mplier(m_b),
    .product(m_p), .done(m_done)
  );

  assign s_axis_tready = (state == gru_pkg::ST_IDLE);
  assign out_load      = (state == gru_pkg::ST_DONE) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_clip;
  assign m_axis_tdata  = {out_sin, out_cos, out_second, out_first};

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW:0] e;
    e = {v[DW-1], v};
    return MW'(e[DW-1+1] ? -e : e);
  endfunction

  // Operand selection and signed term for rotation products.
  logic signed [MW:0] coef_s;
  logic signed [DW:0] elem_s;
  logic               prod_neg;
  always_comb begin
    coef_s = '0;
    elem_s = '0;
    term   = 2'd0;
    if (state == gru_pkg::ST_SQUARE) begin
      m_a = tau; m_b = tau;
    end else if (state == gru_pkg::ST_OTHER) begin
      m_a = rval; m_b = tau;
    end else begin
      case (steps[1:0])
        2'd0: begin coef_s = (MW+1)'(cosine); elem_s = (DW+1)'(x); end
        2'd1: begin coef_s = (MW+1)'(sine); elem_s = (DW+1)'(y); end
        2'd2: begin coef_s = (MW+1)'(sine); elem_s = (DW+1)'(x); end
        default: begin coef_s = (MW+1)'(cosine); elem_s = (DW+1)'(y); end
      endcase
      term = steps[1:0];
      m_a = MW'(coef_s[MW] ? -coef_s : coef_s);
      m_b = MW'(elem_s[DW] ? -elem_s : elem_s);
    end
  end
  assign prod_neg = coef_s[MW] ^ elem_s[DW];

  logic signed [PW+1:0] prod_s;
  assign prod_s = prod_neg ? -$signed({2'b00, m_p}) : $signed({2'b00, m_p});

  // Floor shift and saturation of the rotation sum.
  logic signed [PW+1:0] shifted;
  logic signed [DW-1:0] sat_val;
  logic                 sat_clip;
  localparam logic signed [PW+1:0] HI = (PW+2)'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [PW+1:0] LO = -HI - 1;
  always_comb begin
    shifted  = p_acc >>> F;
    sat_clip = 1'b0;
    sat_val  = DW'(shifted);
    if (shifted > HI) begin
      sat_val = {1'b0, {(DW-1){1'b1}}}; sat_clip = 1'b1;
    end else if (shifted < LO) begin
      sat_val = {1'b1, {(DW-1){1'b0}}}; sat_clip = 1'b1;
    end
  end

  // Restoring division step: one quotient bit per cycle.
  logic [NW+1:0] rem_sh, rem_sub;
  assign rem_sh  = {rem[NW:0], num[NW+1]};
  assign rem_sub = rem_sh - (NW+2)'(den);

  // Square root step.
  logic [2*F+3:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  always_comb begin
    state_next = state;
    case (state)
      gru_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser) state_next = gru_pkg::ST_ROT1;
          else if (s_axis_tdata[2*DW-1:DW] == '0) state_next = gru_pkg::ST_DONE;
          else state_next = gru_pkg::ST_DIV;
        end
      gru_pkg::ST_DIV:    if (steps == '0) state_next = gru_pkg::ST_SQUARE;
      gru_pkg::ST_SQUARE: if (m_done) state_next = gru_pkg::ST_SQRT;
      gru_pkg::ST_SQRT:   if (sq_bit == '0) state_next = gru_pkg::ST_RECIP;
      gru_pkg::ST_RECIP:  if (steps == '0) state_next = gru_pkg::ST_OTHER;
      gru_pkg::ST_OTHER:  if (m_done) state_next = gru_pkg::ST_DONE;
      gru_pkg::ST_ROT1:   if (m_done && term == 2'd3) state_next = gru_pkg::ST_DONE;
      gru_pkg::ST_ROT2:   state_next = gru_pkg::ST_ROT1;
      gru_pkg::ST_DONE:   if (out_load) state_next = gru_pkg::ST_IDLE;
      default:            state_next = gru_pkg::ST_IDLE;
    endcase
  end

  logic mul_wait;
  always_comb begin
    mctrl.busy  = 1'b0;
    mctrl.start = 1'b0;
    case (state)
      gru_pkg::ST_SQUARE, gru_pkg::ST_OTHER, gru_pkg::ST_ROT1: begin
        mctrl.busy  = 1'b1;
        mctrl.start = !mul_wait;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gru_pkg::ST_IDLE;
      cosine    <= CW'(1) <<< F;
      sine      <= '0;
      out_valid <= 1'b0;
      out_clip  <= 1'b0;
      mul_wait  <= 1'b0;
      steps     <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid  <= 1'b1;
        out_clip   <= is_rot & clip;
        out_first  <= res1;
        out_second <= res2;
        out_cos    <= cosine;
        out_sin    <= sine;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (mctrl.start) mul_wait <= 1'b1;
      if (m_done) mul_wait <= 1'b0;
      case (state)
        gru_pkg::ST_IDLE:
          if (s_axis_tvalid && s_axis_tready) begin
            x      <= s_axis_tdata[DW-1:0];
            y      <= s_axis_tdata[2*DW-1:DW];
            is_rot <= s_axis_tuser;
            p_acc  <= '0;
            clip   <= 1'b0;
            res1   <= '0;
            res2   <= '0;
            if (!s_axis_tuser) begin
              if (s_axis_tdata[2*DW-1:DW] == '0) begin
                cosine <= CW'(1) <<< F;
                sine   <= '0;
              end else begin
                logic [MW-1:0] a_m, b_m;
                a_m = mag(s_axis_tdata[DW-1:0]);
                b_m = mag(s_axis_tdata[2*DW-1:DW]);
                b_larger <= b_m > a_m;
                neg <= (s_axis_tdata[DW-1] == s_axis_tdata[2*DW-1]) &&
                       (((b_m > a_m) ? a_m : b_m) != '0);
                num   <= (NW+2)'((b_m > a_m) ? a_m : b_m) << F << (NW + 2 - (DW + 1 + F));
                den   <= (b_m > a_m) ? b_m : a_m;
                rem   <= '0;
                quo   <= '0;
                steps <= KW'(DW + 1 + F);
              end
            end else begin
              steps <= '0;
            end
          end
        gru_pkg::ST_DIV, gru_pkg::ST_RECIP: begin
          if (steps != '0) begin
            num   <= num << 1;
            steps <= steps - 1'b1;
            if (!rem_sub[NW+1]) begin
              rem <= rem_sub; quo <= {quo[MW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;  quo <= {quo[MW-2:0], 1'b0};
            end
          end else if (state == gru_pkg::ST_DIV) begin
            tau <= quo;
          end else begin
            rval <= quo;
          end
        end
        gru_pkg::ST_SQUARE:
          if (m_done) begin
            sq_n   <= (2*F+4)'(((m_p >> F) + (PW'(1) << F)) << F);
            sq_res <= '0;
            sq_bit <= (2*F+4)'(1) << (2 * F + 2);
          end
        gru_pkg::ST_SQRT:
          if (sq_bit != '0) begin
            if (sq_n >= sq_try) begin
              sq_n   <= sq_n - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            root  <= MW'(sq_res);
            den   <= MW'(sq_res);
            num   <= (NW+2)'(1) << (NW + 1);
            rem   <= '0;
            quo   <= '0;
            steps <= KW'(2 * F + 1);
          end
        gru_pkg::ST_OTHER:
          if (m_done) begin
            logic [CW-1:0] oth;
            oth = CW'(m_p >> F);
            if (b_larger) begin
              sine   <= CW'(rval);
              cosine <= neg ? -oth : oth;
            end else begin
              cosine <= CW'(rval);
              sine   <= neg ? -oth : oth;
            end
          end
        gru_pkg::ST_ROT1:
          if (m_done) steps <= steps + 1'b1;
        default: ;
      endcase
      // Rotation accumulation: terms 0,1 form the first output, 2,3 the second.
      if (state == gru_pkg::ST_ROT1 && m_done) begin
        case (term)
          2'd0: p_acc <= prod_s;
          2'd1: begin
            logic signed [PW+1:0] s1, sh1;
            s1  = p_acc - prod_s;
            sh1 = s1 >>> F;
            if (sh1 > HI) begin res1 <= HI[DW-1:0]; clip <= 1'b1; end
            else if (sh1 < LO) begin res1 <= LO[DW-1:0]; clip <= 1'b1; end
            else res1 <= DW'(sh1);
            p_acc <= '0;
          end
          2'd2: p_acc <= prod_s;
          default: begin
            logic signed [PW+1:0] s2, sh2;
            s2  = p_acc + prod_s;
            sh2 = s2 >>> F;
            if (sh2 > HI) begin res2 <= HI[DW-1:0]; clip <= 1'b1; end
            else if (sh2 < LO) begin res2 <= LO[DW-1:0]; clip <= 1'b1; end
            else res2 <= DW'(sh2);
          end
        endcase
      end
    end
  end

  logic unused;
  assign unused = ^{root, sat_val, sat_clip, shifted, mctrl.busy};

endmodule

FILE: design/givens_rotation_unit_checker.sv
//------------------------------------------------------------------------------
// givens_rotation_unit_checker
// Port-level checks of the plane rotation unit.
//------------------------------------------------------------------------------
module givens_rotation_unit_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tuser
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("input taken while busy");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

  a_hold_user: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser)) else $error("flag changed");

  a_no_result_at_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
    else $error("result too early");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid) else $error("result after reset");

endmodule

bind givens_rotation_unit givens_rotation_unit_checker u_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tuser(m_axis_tuser)
);

FILE: test/givens_rotation_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// givens_rotation_checker
// Watches both stream channels of the rotation unit, predicts each output
// beat from the accepted input beats with an independent integer model of the
// coefficient and rotation arithmetic, and compares field by field.
//------------------------------------------------------------------------------
module givens_rotation_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           errors,
  output int           pending
);

  localparam int FB = 30;

  typedef struct packed {
    logic [31:0] rot_first;
    logic [31:0] rot_second;
    logic [31:0] cosine;
    logic [31:0] sine;
    logic        clipped;
  } rot_beat_t;

  rot_beat_t   expected_beats[$];
  logic signed [63:0] cos_q;
  logic signed [63:0] sin_q;

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v);
    return v >>> FB;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v, inout logic c);
    if (v > 64'sd2147483647) begin
      c = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      c = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  task automatic predict_rotation(logic mode, logic signed [31:0] x, logic signed [31:0] y);
    rot_beat_t e;
    logic [63:0] ma, mb, sm, lg, tau, q, root, r, oth;
    logic neg, blarge, c;
    logic signed [63:0] p1, p2;
    e = '0;
    c = 1'b0;
    if (!mode) begin
      if (y == 0) begin
        cos_q = 64'sd1 << FB;
        sin_q = 0;
      end else begin
        ma = (x < 0) ? -64'(x) : 64'(x);
        mb = (y < 0) ? -64'(y) : 64'(y);
        blarge = mb > ma;
        sm = blarge ? ma : mb;
        lg = blarge ? mb : ma;
        neg = (sm != 0) && ((x < 0) == (y < 0));
        tau = (sm << FB) / lg;
        q = (64'd1 << FB) + ((tau * tau) >> FB);
        root = isqrt64(q << FB);
        r = (64'd1 << (2 * FB)) / root;
        oth = (r * tau) >> FB;
        if (blarge) begin
          sin_q = r;
          cos_q = neg ? -$signed(oth) : $signed(oth);
        end else begin
          cos_q = r;
          sin_q = neg ? -$signed(oth) : $signed(oth);
        end
      end
    end else begin
      p1 = cos_q * x - sin_q * y;
      p2 = sin_q * x + cos_q * y;
      e.rot_first  = clip32(floor_shift(p1), c);
      e.rot_second = clip32(floor_shift(p2), c);
    end
    e.cosine  = cos_q[31:0];
    e.sine    = sin_q[31:0];
    e.clipped = c;
    expected_beats.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = expected_beats.size();

  always @(posedge clk) begin
    rot_beat_t e;
    if (rst) begin
      cos_q  = 64'sd1 << FB;
      sin_q  = 0;
      errors = 0;
      expected_beats.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[31:0], 0);
        end else begin
          e = expected_beats.pop_front();
          if (m_axis_tdata[31:0] !== e.rot_first)
            report_mismatch("rotated_first", m_axis_tdata[31:0], e.rot_first);
          if (m_axis_tdata[63:32] !== e.rot_second)
            report_mismatch("rotated_second", m_axis_tdata[63:32], e.rot_second);
          if (m_axis_tdata[95:64] !== e.cosine)
            report_mismatch("cosine_out", m_axis_tdata[95:64], e.cosine);
          if (m_axis_tdata[127:96] !== e.sine)
            report_mismatch("sine_out", m_axis_tdata[127:96], e.sine);
          if (m_axis_tuser !== e.clipped)
            report_mismatch("saturated", m_axis_tuser, e.clipped);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_rotation(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
  end

endmodule

FILE: test/tb_givens_rotation_unit.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_givens_rotation_unit
// Drives directed and random compute and rotate beats with random gaps and
// back-pressure; the checker predicts and compares every output beat.
//------------------------------------------------------------------------------
module tb_givens_rotation_unit;

  localparam int LIMIT = 2000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           errors;
  int           pending;
  int           cycles = 0;
  bit           quiet_phase = 1'b0;

  always #10 clk = ~clk;

  givens_rotation_unit DUT (.*);

  givens_rotation_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (quiet_phase) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 39) == 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return $urandom_range(0, 4) - 2;
      4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic mode, logic [31:0] a, logic [31:0] b);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_beat(1'b1, 32'h00010000, 32'hffff0000);
    send_beat(1'b1, 32'h7fffffff, 32'h80000000);
    send_beat(1'b0, 32'h00030000, 32'h00030000);
    send_beat(1'b1, 32'h7fffffff, 32'h7fffffff);
    send_beat(1'b0, 32'hfffd0000, 32'h00030000);
    send_beat(1'b1, 32'h80000000, 32'h80000000);
    send_beat(1'b0, 32'h0, 32'h0);
    send_beat(1'b1, 32'h12345678, 32'h9abcdef0);
    send_beat(1'b0, 32'h0, 32'h00010000);
    send_beat(1'b1, 32'h00020000, 32'h00050000);
    send_beat(1'b0, 32'h0, 32'h80000000);
    send_beat(1'b1, 32'h7fffffff, 32'h7fffffff);
    send_beat(1'b0, 32'h80000000, 32'h7fffffff);
    send_beat(1'b1, 32'h80000000, 32'h7fffffff);
    send_beat(1'b0, 32'h7fffffff, 32'h80000000);
    send_beat(1'b1, 32'h80000000, 32'h80000000);
    send_beat(1'b0, 32'h00000001, 32'h7fffffff);
    send_beat(1'b1, 32'hffffffff, 32'h00000001);
    send_beat(1'b0, 32'h00050000, 32'hffffffff);
    send_beat(1'b1, 32'h40000000, 32'hc0000000);
    for (int i = 0; i < 620; i++) begin
      quiet_phase = (i >= 260 && i < 310);
      if ($urandom_range(0, 3) == 0) begin
        a = pick_value();
        send_beat(1'b0, a, pick_value());
        repeat ($urandom_range(1, 3)) send_beat(1'b1, pick_value(), pick_value());
      end else begin
        send_beat($urandom_range(0, 1), pick_value(), pick_value());
      end
    end
    s_axis_tvalid <= 1'b0;
    quiet_phase = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
